// ===== src/dkax_pkg.sv =====
// shared types, constants and functions for the dual-key aes-128 xor block
// depends on nothing
package dkax_pkg;

    localparam int NumRounds = 10;

    typedef logic [127:0] blk_t;

    // per-stage control travelling with the data
    typedef struct packed {
        logic valid;
        logic dual;
    } stage_ctl_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = tbl[x];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        case (r)
            4'd1: rcon = 8'h01;
            4'd2: rcon = 8'h02;
            4'd3: rcon = 8'h04;
            4'd4: rcon = 8'h08;
            4'd5: rcon = 8'h10;
            4'd6: rcon = 8'h20;
            4'd7: rcon = 8'h40;
            4'd8: rcon = 8'h80;
            4'd9: rcon = 8'h1b;
            4'd10: rcon = 8'h36;
            default: rcon = 8'h00;
        endcase
    endfunction

    // next round key; byte n at bits 8n+7:8n
    function automatic blk_t next_key(input blk_t k, input logic [3:0] r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[31:0];
        w1 = k[63:32];
        w2 = k[95:64];
        w3 = k[127:96];
        t = {sbox(w3[7:0]), sbox(w3[31:24]), sbox(w3[23:16]),
             sbox(w3[15:8]) ^ rcon(r)};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w3, w2, w1, w0};
    endfunction

    // sub bytes, shift rows and optionally mix columns
    function automatic blk_t round_fn(input blk_t s, input logic mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        blk_t o;
        for (int c = 0; c < 4; c++) begin
            for (int n = 0; n < 4; n++) begin
                t[n + 4 * c] = sbox(s[8 * (n + 4 * ((c + n) % 4)) +: 8]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            if (mix) begin
                o[32 * c +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                o[32 * c + 8 +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                o[32 * c + 16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                o[32 * c + 24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
            else begin
                o[32 * c +: 32] = {a3, a2, a1, a0};
            end
        end
        round_fn = o;
    endfunction

endpackage

// ===== src/dkax_round_cell.sv =====
// one round cell: both cipher lanes and both key schedules for one aes round
// depends on dkax_pkg
module dkax_round_cell #(
    parameter logic [3:0] ROUND = 4'd1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  dkax_pkg::stage_ctl_t ctl_in,
    input  dkax_pkg::blk_t     st_a_in,
    input  dkax_pkg::blk_t     st_b_in,
    input  dkax_pkg::blk_t     key_a_in,
    input  dkax_pkg::blk_t     key_b_in,
    output dkax_pkg::stage_ctl_t ctl_out,
    output dkax_pkg::blk_t     st_a_out,
    output dkax_pkg::blk_t     st_b_out,
    output dkax_pkg::blk_t     key_a_out,
    output dkax_pkg::blk_t     key_b_out
);
    import dkax_pkg::*;

    localparam logic MIX = (ROUND != 4'(NumRounds));

    blk_t st_a_reg, st_b_reg, key_a_reg, key_b_reg;
    blk_t key_a_next, key_b_next;
    stage_ctl_t ctl_reg;

    assign key_a_next = next_key(key_a_in, ROUND);
    assign key_b_next = next_key(key_b_in, ROUND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_a_reg  <= round_fn(st_a_in, MIX) ^ key_a_next;
            st_b_reg  <= round_fn(st_b_in, MIX) ^ key_b_next;
            key_a_reg <= key_a_next;
            key_b_reg <= key_b_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign st_a_out  = st_a_reg;
    assign st_b_out  = st_b_reg;
    assign key_a_out = key_a_reg;
    assign key_b_out = key_b_reg;
endmodule

// ===== src/dual_key_aes128_xor.sv =====
// dual-key aes-128 xor: top level with input stage, ten round cells, output stage
// input stage, ten round cells and output register lie between input acceptance and
// output valid; throughput one item per cycle while the chain is not stalled, set by
// the unrolled chain of round cells which advances as a whole
// the chain stalls only when the output register is full and not taken
// reset clears all valid flags; data registers are not reset
// depends on dkax_pkg and dkax_round_cell
module dual_key_aes128_xor (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // msg_lo, msg_hi, key_a_lo, key_a_hi, key_b_lo, key_b_hi from bit 0 up
    input  logic [383:0] s_tdata,
    // operation
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_lo, result_hi from bit 0 up
    output logic [127:0] m_tdata
);
    import dkax_pkg::*;

    localparam int NumCells = NumRounds;

    stage_ctl_t ctl [NumCells + 1];
    blk_t st_a [NumCells + 1];
    blk_t st_b [NumCells + 1];
    blk_t key_a [NumCells + 1];
    blk_t key_b [NumCells + 1];

    stage_ctl_t ctl_reg;
    blk_t st_a_reg, st_b_reg, key_a_reg, key_b_reg;
    logic out_valid_reg;
    blk_t out_data_reg;
    logic en;
    blk_t msg;

    // whole chain advances unless the output register holds an untaken item
    assign en = !(out_valid_reg && !m_tready);
    assign s_tready = en;
    assign msg = s_tdata[127:0];

    // input stage: initial add round key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= '{valid: s_tvalid, dual: s_tuser[0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_a_reg  <= msg ^ s_tdata[255:128];
            st_b_reg  <= msg ^ s_tdata[383:256];
            key_a_reg <= s_tdata[255:128];
            key_b_reg <= s_tdata[383:256];
        end
    end

    assign ctl[0]   = ctl_reg;
    assign st_a[0]  = st_a_reg;
    assign st_b[0]  = st_b_reg;
    assign key_a[0] = key_a_reg;
    assign key_b[0] = key_b_reg;

    // chain of round cells
    for (genvar i = 0; i < NumCells; i++)
    begin : g_cell
        dkax_round_cell #(
            .ROUND(4'(i + 1))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (ctl[i]),
            .st_a_in  (st_a[i]),
            .st_b_in  (st_b[i]),
            .key_a_in (key_a[i]),
            .key_b_in (key_b[i]),
            .ctl_out  (ctl[i + 1]),
            .st_a_out (st_a[i + 1]),
            .st_b_out (st_b[i + 1]),
            .key_a_out(key_a[i + 1]),
            .key_b_out(key_b[i + 1])
        );
    end

    // output register: combine the two lanes in dual mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl[NumCells].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= ctl[NumCells].dual ? (st_a[NumCells] ^ st_b[NumCells])
                                               : st_a[NumCells];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

// ===== bench/tb_dual_key_aes128_xor.sv =====
// testbench for the dual-key aes-128 xor block: streams plaintext and key pairs in,
// checks each result against a behavioural aes-128 encryption written here
// depends on dkax_pkg and dual_key_aes128_xor
`timescale 1ns / 1ps

module tb_dual_key_aes128_xor;

    import dkax_pkg::*;

    typedef enum logic [0:0] {
        OP_SINGLE = 1'b0,
        OP_DUAL   = 1'b1
    } aes_op_e;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } half_pair_t;

    localparam int  LATENCY    = 12;
    localparam int  IDLE_LIMIT = 4000;
    localparam int  RAND_ITEMS = 1430;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [383:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;

    // expected ciphertexts in arrival order
    blk_t         cipher_q[$];
    int           mismatches;
    int           idle_cycles;
    bit           timed_out;
    bit           quiet_phase;   // no random idling on either side
    bit           rx_hold_req;   // ask the receiver to hold off for a long stretch
    bit           rx_holding;
    logic [7:0]   sbox_lut[256];

    dual_key_aes128_xor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // msg_lo, msg_hi, key_a_lo, key_a_hi, key_b_lo, key_b_hi from bit 0 up
        .s_tdata  (s_tdata),
        // operation
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // result_lo, result_hi from bit 0 up
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // ---------------- behavioural aes-128 ----------------

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                p = p ^ a;
            b = b >> 1;
            a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
        end
        return p;
    endfunction

    // s-box from the field inverse (x^254) and the affine map
    function automatic logic [7:0] calc_sbox(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] b;
        logic [7:0] y;
        r = 8'h01;
        b = x;
        for (int e = 254; e != 0; e = e >> 1)
        begin
            if (e & 1)
                r = gmul(r, b);
            b = gmul(b, b);
        end
        y = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
            ^ {r[3:0], r[7:4]} ^ 8'h63;
        return y;
    endfunction

    function automatic blk_t aes_encrypt(input blk_t key, input blk_t msg);
        logic [7:0] rk[176];
        logic [7:0] st[16];
        logic [7:0] sh[16];
        logic [7:0] w[4];
        logic [7:0] tmp;
        logic [7:0] rc;
        blk_t       res;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[8 * i +: 8];
            st[i] = msg[8 * i +: 8] ^ key[8 * i +: 8];
        end
        rc = 8'h01;
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                w[j] = rk[i - 4 + j];
            if (i % 16 == 0)
            begin
                tmp  = w[0];
                w[0] = sbox_lut[w[1]] ^ rc;
                w[1] = sbox_lut[w[2]];
                w[2] = sbox_lut[w[3]];
                w[3] = sbox_lut[tmp];
                rc   = gmul(rc, 8'h02);
            end
            for (int j = 0; j < 4; j++)
                rk[i + j] = rk[i - 16 + j] ^ w[j];
        end
        for (int r = 1; r <= 10; r++)
        begin
            // substitution with row n rotated left by n columns
            for (int c = 0; c < 4; c++)
                for (int n = 0; n < 4; n++)
                    sh[n + 4 * c] = sbox_lut[st[n + 4 * ((c + n) % 4)]];
            for (int c = 0; c < 4; c++)
            begin
                if (r < 10)
                begin
                    st[4*c]   = gmul(sh[4*c], 2) ^ gmul(sh[4*c+1], 3) ^ sh[4*c+2] ^ sh[4*c+3];
                    st[4*c+1] = sh[4*c] ^ gmul(sh[4*c+1], 2) ^ gmul(sh[4*c+2], 3) ^ sh[4*c+3];
                    st[4*c+2] = sh[4*c] ^ sh[4*c+1] ^ gmul(sh[4*c+2], 2) ^ gmul(sh[4*c+3], 3);
                    st[4*c+3] = gmul(sh[4*c], 3) ^ sh[4*c+1] ^ sh[4*c+2] ^ gmul(sh[4*c+3], 2);
                end
                else
                begin
                    for (int n = 0; n < 4; n++)
                        st[4*c+n] = sh[4*c+n];
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] = st[i] ^ rk[16 * r + i];
        end
        for (int i = 0; i < 16; i++)
            res[8 * i +: 8] = st[i];
        return res;
    endfunction

    // ---------------- driving ----------------

    // offer one item on the falling edge and hold it until it is taken;
    // valid stays high afterwards so the next item can follow directly
    task automatic send_block(input aes_op_e op, input blk_t msg, input blk_t key_a,
                              input blk_t key_b);
        blk_t expected;
        expected = aes_encrypt(key_a, msg);
        if (op == OP_DUAL)
            expected = expected ^ aes_encrypt(key_b, msg);
        // random idle before offering
        while (!quiet_phase && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {key_b, key_a, msg};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        cipher_q.push_back(expected);
        @(negedge clk);
    endtask

    function automatic blk_t rand_blk();
        blk_t v;
        for (int i = 0; i < 4; i++)
            v[32 * i +: 32] = $urandom;
        return v;
    endfunction

    // random value biased towards all-zeros, all-ones and walking bits
    function automatic blk_t shaped_blk();
        blk_t v;
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = '1;
            2:       v = blk_t'(1) << $urandom_range(127);
            3:       v = ~(blk_t'(1) << $urandom_range(127));
            default: v = rand_blk();
        endcase
        return v;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (cipher_q.size() != 0 && !timed_out)
            @(negedge clk);
    endtask

    // ---------------- receiver and checker ----------------

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_holding)
            m_tready <= 1'b0;
        else if (quiet_phase)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 12);
    end

    // long hold-off counted here while the sender keeps offering
    initial
    begin
        rx_holding = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_holding = 1'b1;
                repeat (200) @(negedge clk);
                rx_holding  = 1'b0;
                rx_hold_req = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cipher_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                half_pair_t exp_r;
                half_pair_t got_r;
                exp_r = cipher_q.pop_front();
                got_r = m_tdata;
                if (got_r.lo !== exp_r.lo || got_r.hi !== exp_r.hi)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: lo exp %h got %h, hi exp %h got %h",
                                 exp_r.lo, got_r.lo, exp_r.hi, got_r.hi);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // known answer vectors from the standard plus field extremes
    task automatic test_directed();
        blk_t k;
        blk_t p;
        // standard appendix vector, key 2b7e..., plaintext 3243...
        k = 128'h3c4fcf098815f7aba6d2ae2816157e2b;
        p = 128'h340737e0a29831318d305a88a8f64332;
        send_block(OP_SINGLE, p, k, '0);
        send_block(OP_SINGLE, p, k, '1);
        send_block(OP_DUAL, p, k, k);          // equal keys cancel to zero
        send_block(OP_DUAL, p, k, '0);
        send_block(OP_SINGLE, '0, '0, '0);
        send_block(OP_SINGLE, '1, '1, '1);
        send_block(OP_DUAL, '0, '0, '1);
        send_block(OP_DUAL, '1, '1, '0);
        send_block(OP_SINGLE, '1, '0, rand_blk());
        send_block(OP_SINGLE, '0, '1, rand_blk());
        send_block(OP_DUAL, '1, '0, '1);
        send_block(OP_DUAL, '0, '1, '0);
        for (int i = 0; i < 4; i++)
            send_block(aes_op_e'(i[0]), blk_t'(1) << (i * 37), rand_blk(), rand_blk());
        wait_drained();
    endtask

    task automatic test_random_stream();
        for (int i = 0; i < RAND_ITEMS && !timed_out; i++)
        begin
            // one long stretch with no idling on either side
            quiet_phase = (i >= 300 && i < 500);
            send_block(aes_op_e'($urandom_range(1)), shaped_blk(), shaped_blk(),
                       shaped_blk());
        end
        quiet_phase = 1'b0;
    endtask

    // receiver stalls while the sender keeps pushing, then sender pauses to drain
    task automatic test_backpressure();
        rx_hold_req = 1'b1;
        for (int i = 0; i < 40 && !timed_out; i++)
            send_block(aes_op_e'($urandom_range(1)), rand_blk(), rand_blk(), rand_blk());
        wait_drained();
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        quiet_phase = 1'b0;
        rx_hold_req = 1'b0;
        for (int i = 0; i < 256; i++)
            sbox_lut[i] = calc_sbox(8'(i));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_random_stream();
        wait_drained();
        repeat (LATENCY + 4) @(negedge clk);

        if (mismatches == 0 && cipher_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
